### rtl/core/gillespie_two_class_population_step_unit_assert.svh
// assertion macros for the population step unit
`ifndef GILLESPIE_TWO_CLASS_POPULATION_STEP_UNIT_ASSERT_SVH
`define GILLESPIE_TWO_CLASS_POPULATION_STEP_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define GPS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define GPS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define GPS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GPS_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/gps_pkg.sv
// ----------------------------------------------------------------------------
// gps_pkg
// types, constants and codes shared by the population step unit
// ----------------------------------------------------------------------------
package gps_pkg;
	localparam int COUNT_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int TIME_BITS      = 48;
	localparam int RATE_BITS      = 60;
	localparam int MUL_BITS       = 64;
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 48;

	localparam logic [2:0] EV_BIRTH0 = 3'd0;
	localparam logic [2:0] EV_BIRTH1 = 3'd1;
	localparam logic [2:0] EV_MUT10  = 3'd2;
	localparam logic [2:0] EV_MUT01  = 3'd3;
	localparam logic [2:0] EV_DEATH0 = 3'd4;
	localparam logic [2:0] EV_DEATH1 = 3'd5;
	localparam logic [2:0] EV_START  = 3'd6;
	localparam logic [2:0] EV_NONE   = 3'd7;

	localparam logic [CFG_IDX_BITS-1:0] REG_MU    = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SEL   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CAP   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_INIT  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_TOTAL = 3'd4;

	localparam logic [63:0] LN2_Q32 = 64'd2977044472;

	typedef struct packed {
		logic        start_new;
		logic [31:0] uniform_wait;
		logic [31:0] uniform_pick;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  event_kind;
		logic [31:0] count_class0;
		logic [31:0] count_class1;
		logic [47:0] elapsed_time;
		logic        finished;
		logic        extinct;
	} out_item_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_IDLE, OP_LOAD, OP_RATE_MUL, OP_DEATH, OP_SUM, OP_LOGN, OP_LOGSQ,
		OP_LNMUL, OP_WAIT, OP_PICK, OP_APPLY, OP_START
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       go;      // start an op (latched operands)
		logic [2:0] sel;     // which rate / step index
	} dp_cmd_t;

	typedef struct packed {
		logic busy;          // multiplier or divider running
		logic live;          // step allowed (not finished)
		logic total_zero;
	} dp_sts_t;
endpackage

### rtl/core/gps_divider.sv
// ----------------------------------------------------------------------------
// gps_divider
// restoring divider for floor(hi:lo / d) with saturation, one bit a cycle
// ----------------------------------------------------------------------------
module gps_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num_hi,
	input  logic [63:0] num_lo,
	input  logic [63:0] den,
	input  logic [63:0] cap,
	output logic        busy,
	output logic [63:0] quo
);
	import gps_pkg::*;

	logic [63:0] hi_q, lo_q, q_q, d_q, cap_q;
	logic [6:0]  cnt_q;
	logic        sat_q;
	logic [63:0] hi_sh, d_eff;
	logic        carry;

	assign d_eff = (den == '0) ? 64'd1 : den;
	assign carry = hi_q[63];
	assign hi_sh = {hi_q[62:0], lo_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= (num_hi >= d_eff) ? 7'd0 : 7'd64;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hi_q  <= num_hi;
			lo_q  <= num_lo;
			d_q   <= d_eff;
			q_q   <= '0;
			cap_q <= cap;
			sat_q <= (num_hi >= d_eff);
		end else if (cnt_q != '0) begin
			lo_q <= {lo_q[62:0], 1'b0};
			if (carry || hi_sh >= d_q) begin
				hi_q <= hi_sh - d_q;
				q_q  <= {q_q[62:0], 1'b1};
			end else begin
				hi_q <= hi_sh;
				q_q  <= {q_q[62:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quo  = sat_q ? cap_q : ((q_q > cap_q) ? cap_q : q_q);
endmodule

### rtl/core/gps_datapath.sv
// ----------------------------------------------------------------------------
// gps_datapath
// rate registers, shared 32x32 multiplier, log squaring, divider and counts
// ----------------------------------------------------------------------------
module gps_datapath #(
	parameter int COUNT_BITS = gps_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = gps_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  gps_pkg::dp_cmd_t    cmd,
	output gps_pkg::dp_sts_t    sts,
	input  gps_pkg::in_item_t   item,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [47:0]         cfg_data,
	output gps_pkg::out_item_t  result
);
	import gps_pkg::*;

	localparam int G = FRAC_BITS + 8;
	localparam logic [63:0] ONE_TENTH = 64'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [63:0] CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;
	localparam logic [63:0] T_MAX = (64'd1 << TIME_BITS) - 64'd1;
	localparam logic [63:0] R_CAP = (64'd1 << RATE_BITS) - 64'd1;

	// configuration
	logic [31:0] mu_q, cap_q, init_q;
	logic [24:0] sel_q;
	logic [47:0] total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mu_q <= '0; sel_q <= '0; cap_q <= 32'd1000; init_q <= 32'd100;
			total_q <= 48'd400 << FRAC_BITS;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MU:    mu_q    <= cfg_data[31:0];
				REG_SEL:   sel_q   <= cfg_data[24:0];
				REG_CAP:   cap_q   <= cfg_data[31:0];
				REG_INIT:  init_q  <= cfg_data[31:0];
				REG_TOTAL: total_q <= cfg_data[47:0];
				default: ;
			endcase
		end
	end

	// state
	logic [63:0] n0_q, n1_q, t_q;
	logic [2:0]  kind_q;
	logic [63:0] rate_q [6];
	logic [63:0] tot_q, lnv_q, target_q, dt_q;
	logic [63:0] m_q;
	logic [63:0] frac_q;
	logic [5:0]  e_q;
	logic [63:0] f1;
	logic signed [26:0] f1s;

	assign f1s = 27'(signed'(ONE_TENTH[26:0])) + 27'(signed'(sel_q));
	assign f1 = f1s[26] ? 64'd0 : 64'(f1s);

	// operand select for the current op
	logic [63:0] ma, mb;
	always_comb begin
		ma = '0; mb = '0;
		case (cmd.op)
			OP_RATE_MUL: begin
				case (cmd.sel)
					3'd0: begin ma = ONE_TENTH; mb = n0_q; end
					3'd1: begin ma = f1;        mb = n1_q; end
					3'd2: begin ma = 64'(mu_q); mb = n1_q; end
					default: begin ma = 64'(mu_q); mb = n0_q; end
				endcase
			end
			OP_DEATH:  begin ma = (cmd.sel == 3'd4) ? n0_q : n1_q;
				mb = rate_q[0] + rate_q[1]; end
			OP_LNMUL:  begin ma = ((64'(32) - 64'(e_q)) << G) - frac_q; mb = LN2_Q32; end
			OP_WAIT:   begin ma = lnv_q; mb = 64'd1 << FRAC_BITS; end
			OP_PICK:   begin ma = 64'(item.uniform_pick); mb = tot_q; end
			default: ;
		endcase
	end

	// scaling: variable divisors go to the divider, powers of two are shifts
	logic [63:0] den_c, cap_c;
	logic [5:0]  shamt_c;
	logic        use_div_c;

	always_comb begin
		den_c = 64'd1; cap_c = R_CAP; shamt_c = '0; use_div_c = 1'b0;
		case (cmd.op)
			OP_RATE_MUL: if (cmd.sel >= 3'd2) shamt_c = 6'(32 - FRAC_BITS);
			OP_DEATH:    begin den_c = 64'(cap_q); use_div_c = 1'b1; end
			OP_LNMUL:    shamt_c = 6'(32 + G - FRAC_BITS);
			OP_WAIT:     begin den_c = tot_q; cap_c = T_MAX; use_div_c = 1'b1; end
			OP_PICK:     begin shamt_c = 6'd32; cap_c = R_CAP << 3; end
			default: ;
		endcase
	end

	// operands latched at go, then four 32x32 partial products into acc_q
	logic [63:0]  ma_q, mb_q, den_q, dcap_q;
	logic [5:0]   shamt_q;
	logic         use_div_q;
	logic [127:0] acc_q;
	logic [2:0]   mph_q;
	logic         div_go_q;
	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [6:0]   pp_sh;
	logic [127:0] pp_al;

	always_comb begin
		case (mph_q)
			3'd4: begin pa = ma_q[31:0];  pb = mb_q[31:0];  pp_sh = 7'd0;  end
			3'd3: begin pa = ma_q[31:0];  pb = mb_q[63:32]; pp_sh = 7'd32; end
			3'd2: begin pa = ma_q[63:32]; pb = mb_q[31:0];  pp_sh = 7'd32; end
			default: begin pa = ma_q[63:32]; pb = mb_q[63:32]; pp_sh = 7'd64; end
		endcase
		pp = 64'(pa) * 64'(pb);
		pp_al = {64'd0, pp} << pp_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mph_q <= '0; div_go_q <= 1'b0;
		end else begin
			div_go_q <= (mph_q == 3'd1);
			if (cmd.go) mph_q <= 3'd4;
			else if (mph_q != '0) mph_q <= mph_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			ma_q <= ma; mb_q <= mb; den_q <= den_c; dcap_q <= cap_c;
			shamt_q <= shamt_c; use_div_q <= use_div_c; acc_q <= '0;
		end else if (mph_q != '0) begin
			acc_q <= acc_q + pp_al;
		end
	end

	logic         dbusy;
	logic [63:0]  div_quo;
	logic [63:0]  dq;
	logic [127:0] shr;
	logic [63:0]  sh_quo;
	logic         unit_busy;

	gps_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go_q && use_div_q),
		.num_hi(acc_q[127:64]), .num_lo(acc_q[63:0]), .den(den_q), .cap(dcap_q),
		.busy(dbusy), .quo(div_quo)
	);

	assign shr = acc_q >> shamt_q;
	assign sh_quo = (shr > {64'd0, dcap_q}) ? dcap_q : shr[63:0];
	assign dq = use_div_q ? div_quo : sh_quo;
	assign unit_busy = dbusy || div_go_q || (mph_q != '0);

	// log normalize: x nonzero, top bit index
	logic [31:0] x;
	logic [5:0]  e_c;
	assign x = (item.uniform_wait == '0) ? 32'd1 : item.uniform_wait;
	always_comb begin
		e_c = '0;
		for (int i = 0; i < 32; i++) if (x[i]) e_c = 6'(i);
	end

	logic [63:0] sq;
	assign sq = m_q[31:0] * m_q[31:0];

	// event choice from cumulative rates
	logic [63:0] c0, c1, c2, c3, c4;
	logic [2:0]  k_c;
	always_comb begin
		c0 = rate_q[0]; c1 = c0 + rate_q[1]; c2 = c1 + rate_q[2];
		c3 = c2 + rate_q[3]; c4 = c3 + rate_q[4];
		if (c0 > target_q)      k_c = EV_BIRTH0;
		else if (c1 > target_q) k_c = EV_BIRTH1;
		else if (c2 > target_q) k_c = EV_MUT10;
		else if (c3 > target_q) k_c = EV_MUT01;
		else if (c4 > target_q) k_c = EV_DEATH0;
		else                    k_c = EV_DEATH1;
	end

	function automatic logic [63:0] inc_s(input logic [63:0] n);
		return (n >= CNT_MAX) ? CNT_MAX : n + 64'd1;
	endfunction
	function automatic logic [63:0] dec_f(input logic [63:0] n);
		return (n == '0) ? n : n - 64'd1;
	endfunction

	logic [63:0] tsum;
	assign tsum = t_q + dt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n0_q <= '0; n1_q <= '0; t_q <= '0; kind_q <= EV_NONE;
		end else begin
			case (cmd.op)
				OP_LOAD:  kind_q <= EV_NONE;
				OP_START: begin
					n0_q <= (64'(init_q) > CNT_MAX) ? CNT_MAX : 64'(init_q);
					n1_q <= '0; t_q <= '0; kind_q <= EV_START;
				end
				OP_APPLY: begin
					t_q <= (tsum > T_MAX) ? T_MAX : tsum;
					kind_q <= k_c;
					case (k_c)
						EV_BIRTH0: n0_q <= inc_s(n0_q);
						EV_BIRTH1: n1_q <= inc_s(n1_q);
						EV_MUT10:  begin n1_q <= dec_f(n1_q); n0_q <= inc_s(n0_q); end
						EV_MUT01:  begin n0_q <= dec_f(n0_q); n1_q <= inc_s(n1_q); end
						EV_DEATH0: n0_q <= dec_f(n0_q);
						default:   n1_q <= dec_f(n1_q);
					endcase
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_RATE_MUL, OP_DEATH: if (!cmd.go && !unit_busy) rate_q[cmd.sel] <= dq;
			OP_SUM:   tot_q <= rate_q[0] + rate_q[1] + rate_q[2] + rate_q[3]
				+ rate_q[4] + rate_q[5];
			OP_LOGN:  begin
				e_q <= e_c; m_q <= 64'(x) << (6'd31 - e_c); frac_q <= '0;
			end
			OP_LOGSQ: begin
				frac_q <= {frac_q[62:0], sq[63]};
				m_q <= sq[63] ? 64'(sq[63:32]) : 64'(sq[62:31]);
			end
			OP_LNMUL: if (!cmd.go && !unit_busy) lnv_q <= dq;
			OP_WAIT:  if (!cmd.go && !unit_busy) dt_q <= dq;
			OP_PICK:  if (!cmd.go && !unit_busy) target_q <= dq;
			default: ;
		endcase
	end

	assign sts.busy = unit_busy;
	assign sts.live = (t_q < 64'(total_q));
	assign sts.total_zero = (tot_q == '0);

	assign result.event_kind   = kind_q;
	assign result.count_class0 = n0_q[31:0];
	assign result.count_class1 = n1_q[31:0];
	assign result.elapsed_time = t_q[47:0];
	assign result.finished     = (t_q >= 64'(total_q));
	assign result.extinct      = (n0_q == '0) && (n1_q == '0);
endmodule

### rtl/core/gps_control.sv
// ----------------------------------------------------------------------------
// gps_control
// sequencer for one step: rates, log, waiting time, pick, apply
// ----------------------------------------------------------------------------
module gps_control #(
	parameter int FRAC_BITS = gps_pkg::FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_start_new,
	output logic              in_stall,
	output gps_pkg::dp_cmd_t  cmd,
	input  gps_pkg::dp_sts_t  sts,
	output logic              out_valid,
	input  logic              out_stall
);
	import gps_pkg::*;
	`include "gillespie_two_class_population_step_unit_assert.svh"

	localparam int G = FRAC_BITS + 8;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001, S_MUL = 7'b0000010, S_WAITD = 7'b0000100,
		S_SUM = 7'b0001000, S_LOG = 7'b0010000, S_APPLY = 7'b0100000,
		S_OUT = 7'b1000000
	} state_t;

	state_t st_q;
	logic [2:0] sel_q;   // rate index, or 6 = ln mul, 7 = wait div, then pick
	logic [1:0] ph_q;    // log sub phase: 0 normalize, 1 square
	logic [4:0] it_q;
	logic       pick_q;
	logic       take;

	assign take = in_valid && !in_stall;
	assign in_stall = (st_q != S_IDLE);
	assign out_valid = (st_q == S_OUT);

	always_comb begin
		cmd.op = OP_IDLE; cmd.go = 1'b0; cmd.sel = sel_q;
		case (st_q)
			S_IDLE:  if (take) cmd.op = in_start_new ? OP_START : OP_LOAD;
			S_MUL, S_WAITD: begin
				if (pick_q) cmd.op = OP_PICK;
				else if (sel_q <= 3'd3) cmd.op = OP_RATE_MUL;
				else if (sel_q <= 3'd5) cmd.op = OP_DEATH;
				else if (sel_q == 3'd6) cmd.op = OP_LNMUL;
				else cmd.op = OP_WAIT;
				cmd.go = (st_q == S_MUL);
			end
			S_SUM:   cmd.op = OP_SUM;
			S_LOG:   cmd.op = (it_q == '0 && ph_q == 2'd0) ? OP_LOGN : OP_LOGSQ;
			S_APPLY: cmd.op = OP_APPLY;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; sel_q <= '0; ph_q <= '0; it_q <= '0; pick_q <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: if (take) begin
					sel_q <= '0; pick_q <= 1'b0; it_q <= '0; ph_q <= '0;
					if (in_start_new || !sts.live) st_q <= S_OUT;
					else st_q <= S_MUL;
				end
				S_MUL: st_q <= S_WAITD;
				S_WAITD: if (!sts.busy) begin
					// result captured this cycle
					if (pick_q) st_q <= S_APPLY;
					else if (sel_q == 3'd5) st_q <= S_SUM;
					else if (sel_q == 3'd7) begin pick_q <= 1'b1; st_q <= S_MUL; end
					else begin sel_q <= sel_q + 3'd1; st_q <= S_MUL; end
				end
				S_SUM: begin
					st_q <= S_LOG; ph_q <= '0; it_q <= '0;
				end
				S_LOG: begin
					if (sts.total_zero) st_q <= S_OUT;
					else if (ph_q == 2'd0) ph_q <= 2'd1;
					else if (it_q == 5'(G - 1)) begin sel_q <= 3'd6; st_q <= S_MUL; end
					else it_q <= it_q + 5'd1;
				end
				S_APPLY: st_q <= S_OUT;
				S_OUT: if (!out_stall) st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	`GPS_ASSERT_IMP(a_no_take_busy, clk, arst_n, st_q != S_IDLE, in_stall)
	`GPS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`GPS_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(st_q))
endmodule

### rtl/core/gillespie_two_class_population_step_unit.sv
// a restart or a finished run gives its result beat in the cycle after it is accepted; a
// full step ends early when the total rate is zero
// the shared 32x32 multiplier is used four times per product, and a one-bit-a-cycle divider
// serves the two death rates and the waiting time; power-of-two scalings are shifts
// the next item is taken only after the result beat
// reset: counts and time zero, registers to defaults, no beat pending
// ----------------------------------------------------------------------------
// gillespie_two_class_population_step_unit
// one direct-method stochastic step of a two-class population
// ----------------------------------------------------------------------------
module gillespie_two_class_population_step_unit #(
	parameter int COUNT_BITS = gps_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = gps_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  gps_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output gps_pkg::out_item_t  out_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_idx,
	input  logic [47:0]         cfg_data
);
	import gps_pkg::*;

	dp_cmd_t   cmd;
	dp_sts_t   sts;
	in_item_t  item_q;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) item_q <= in_data;
	end

	gps_control #(.FRAC_BITS(FRAC_BITS)) u_ctl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid),
		.in_start_new(in_data.start_new), .in_stall(in_stall),
		.cmd(cmd), .sts(sts), .out_valid(out_valid), .out_stall(out_stall)
	);

	gps_datapath #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .item(item_q),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data), .result(out_data)
	);
endmodule
